### rtl/assert_macros.svh
// Assertion macros for the checker module of the address cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define ARPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("arp cache check failed");

// Next-cycle implication, checked while reset is released.
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("arp cache check failed");

`endif

### rtl/arpc_pkg.sv
// Shared constants, codes and bundle types of the address resolution cache.
package arpc_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned IpW        = 32;
  localparam int unsigned MacW       = 48;
  localparam int unsigned StatusW    = 3;

  typedef enum logic [StatusW-1:0] {
    StHit     = 3'd0,
    StMiss    = 3'd1,
    StUpdated = 3'd2,
    StAdded   = 3'd3,
    StFull    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    StateIdle = 2'b01,
    StateScan = 2'b10
  } state_e;

  typedef struct packed {
    logic [IdxW-1:0] rd_addr;
    logic            ip_we;
    logic            mac_we;
    logic [IdxW-1:0] wr_addr;
    logic [IpW-1:0]  wr_ip;
    logic [MacW-1:0] wr_mac;
  } ram_req_t;

  typedef struct packed {
    logic            valid;
    status_e         status;
    logic [MacW-1:0] mac;
  } res_t;

endpackage

### rtl/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/arpc_ctrl.sv
// Sequencer that walks the occupied slots with one shared key comparator.
module arpc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      action_i,
  input  logic [arpc_pkg::IpW-1:0]  ip_address_i,
  input  logic [arpc_pkg::MacW-1:0] mac_address_i,
  output logic                      busy_o,
  input  logic                      out_free_i,
  input  logic [arpc_pkg::IpW-1:0]  ip_rdata_i,
  input  logic [arpc_pkg::MacW-1:0] mac_rdata_i,
  output arpc_pkg::ram_req_t        ram_o,
  output arpc_pkg::res_t            res_o
);

  arpc_pkg::state_e                state_q, state_d;
  logic [arpc_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [arpc_pkg::CntW-1:0]       count_q, count_d;
  logic                            act_q;
  logic [arpc_pkg::IpW-1:0]        key_q;
  logic [arpc_pkg::MacW-1:0]       mac_q;

  logic [arpc_pkg::CntW-1:0]       idx_ext;
  logic [arpc_pkg::CntW-1:0]       idx_inc;
  logic                            occupied;
  logic                            hit;
  logic                            last;
  logic                            done;
  logic                            table_full;
  logic                            accept;

  assign accept     = in_valid_i && (state_q == arpc_pkg::StateIdle);
  assign idx_ext    = arpc_pkg::CntW'(idx_q);
  assign idx_inc    = idx_ext + arpc_pkg::CntW'(1);
  // The RAM shows the slot addressed in the previous cycle; only occupied slots may match.
  assign occupied   = idx_ext < count_q;
  assign hit        = occupied && (ip_rdata_i == key_q);
  assign last       = idx_inc >= count_q;
  assign done       = hit || last;
  assign table_full = count_q == arpc_pkg::CntW'(arpc_pkg::TableDepth);

  assign busy_o = (state_q != arpc_pkg::StateIdle);

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    count_d        = count_q;
    ram_o.ip_we    = 1'b0;
    ram_o.mac_we   = 1'b0;
    ram_o.wr_addr  = idx_q;
    ram_o.wr_ip    = key_q;
    ram_o.wr_mac   = mac_q;
    res_o.valid    = 1'b0;
    res_o.status   = arpc_pkg::StMiss;
    res_o.mac      = '0;

    unique case (state_q)
      arpc_pkg::StateIdle: begin
        if (accept) begin
          idx_d   = '0;
          state_d = arpc_pkg::StateScan;
        end
      end
      arpc_pkg::StateScan: begin
        if (!done) begin
          idx_d = arpc_pkg::IdxW'(idx_inc);
        end else if (out_free_i) begin
          state_d     = arpc_pkg::StateIdle;
          res_o.valid = 1'b1;
          if (hit) begin
            if (act_q) begin
              ram_o.mac_we = 1'b1;
              res_o.status = arpc_pkg::StUpdated;
            end else begin
              res_o.status = arpc_pkg::StHit;
              res_o.mac    = mac_rdata_i;
            end
          end else if (act_q) begin
            if (table_full) begin
              res_o.status = arpc_pkg::StFull;
            end else begin
              ram_o.ip_we   = 1'b1;
              ram_o.mac_we  = 1'b1;
              ram_o.wr_addr = arpc_pkg::IdxW'(count_q);
              count_d       = count_q + arpc_pkg::CntW'(1);
              res_o.status  = arpc_pkg::StAdded;
            end
          end else begin
            res_o.status = arpc_pkg::StMiss;
          end
        end
      end
      default: begin
        state_d = arpc_pkg::StateIdle;
      end
    endcase

    // The read address follows the slot index, so a held result keeps its data.
    ram_o.rd_addr = idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpc_pkg::StateIdle;
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      key_q <= ip_address_i;
      mac_q <= mac_address_i;
    end
  end

endmodule

### rtl/arp_cache_table_core.sv
// Address cache: one key comparator walks the address RAM one slot a cycle.
// The result is registered after the first compare on an empty table or a match in
// slot 0, and after the last occupied slot when none matches. A new request is not
// taken until the sequencer is back in idle, which it reaches as the result is
// registered, so a result waiting behind a stalled one holds off the next request.
// Reset clears the sequencer, the entry count and the output valid, not the slot RAMs.
module arp_cache_table_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [arpc_pkg::IpW-1:0]    ip_address_i,
  input  logic [arpc_pkg::MacW-1:0]   mac_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [arpc_pkg::StatusW-1:0] status_o,
  output logic [arpc_pkg::MacW-1:0]   mac_found_o
);

  arpc_pkg::ram_req_t              ram_req;
  arpc_pkg::res_t                  res;
  logic [arpc_pkg::IpW-1:0]        ip_rdata;
  logic [arpc_pkg::MacW-1:0]       mac_rdata;
  logic                            busy;
  logic                            out_free;
  logic                            out_valid_q;
  arpc_pkg::status_e               status_q;
  logic [arpc_pkg::MacW-1:0]       mac_found_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy;

  arpc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .action_i      (action_i),
    .ip_address_i  (ip_address_i),
    .mac_address_i (mac_address_i),
    .busy_o        (busy),
    .out_free_i    (out_free),
    .ip_rdata_i    (ip_rdata),
    .mac_rdata_i   (mac_rdata),
    .ram_o         (ram_req),
    .res_o         (res)
  );

  arpc_ram #(
    .Width (arpc_pkg::IpW),
    .Depth (arpc_pkg::TableDepth)
  ) u_ip_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.ip_we),
    .waddr_i (ram_req.wr_addr),
    .wdata_i (ram_req.wr_ip),
    .raddr_i (ram_req.rd_addr),
    .rdata_o (ip_rdata)
  );

  arpc_ram #(
    .Width (arpc_pkg::MacW),
    .Depth (arpc_pkg::TableDepth)
  ) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.mac_we),
    .waddr_i (ram_req.wr_addr),
    .wdata_i (ram_req.wr_mac),
    .raddr_i (ram_req.rd_addr),
    .rdata_o (mac_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q    <= res.status;
      mac_found_q <= res.mac;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign mac_found_o = mac_found_q;

endmodule

### rtl/arpc_checker.sv
// Port-level checker for the address cache, bound to the top level.
`include "assert_macros.svh"

module arpc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [arpc_pkg::StatusW-1:0] status_o,
  input logic [arpc_pkg::MacW-1:0]    mac_found_o
);

  logic                                       in_beat;
  logic                                       out_wait;
  logic                                       status_known;
  logic [arpc_pkg::StatusW+arpc_pkg::MacW-1:0] out_data;

  assign in_beat      = in_valid_i && !in_stall_o;
  assign out_wait     = out_valid_o && out_stall_i;
  assign out_data     = {status_o, mac_found_o};
  assign status_known = (status_o == arpc_pkg::StHit) || (status_o == arpc_pkg::StMiss) ||
                        (status_o == arpc_pkg::StUpdated) || (status_o == arpc_pkg::StAdded) ||
                        (status_o == arpc_pkg::StFull);

  // A stalled result beat keeps its valid and payload.
  `ARPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_data))

  `ARPC_ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid_o, status_known)

  // Among the even status codes, only a resolve hit carries a stored address.
  `ARPC_ASSERT_IMPL(a_mac_zero, clk_i, rst_ni, out_valid_o && !status_o[0], mac_found_o == '0 || status_o == arpc_pkg::StHit)

  // The search is always busy with a compare in the cycle after an accepted beat.
  `ARPC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_beat, in_stall_o)

endmodule

bind arp_cache_table_core arpc_checker u_arpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .mac_found_o (mac_found_o)
);
